// File: sv/bfat_pkg.sv
// Shared types and constants for the bloom filter add/test block.
// No dependencies; imported by the modulo unit and the top level.
package bfat_pkg;

  localparam int KeyW      = 32;
  localparam int ModW      = 13;
  localparam int HcntW     = 3;
  localparam int CfgW      = 64;
  localparam int CfgIdxW   = 3;
  localparam int DividendW = 2 * KeyW;

  localparam logic CmdTest = 1'b0;
  localparam logic CmdAdd  = 1'b1;

  localparam logic [CfgIdxW-1:0] RegBitCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHashCount = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMult01    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMult23    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMult45    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMultSix   = 3'd5;

  localparam logic [ModW-1:0]  BitCountRst  = 13'd4096;
  localparam logic [HcntW-1:0] HashCountRst = 3'd7;
  localparam logic [CfgW-1:0]  Mult01Rst    = 64'd12884901890;
  localparam logic [CfgW-1:0]  Mult23Rst    = 64'd30064771077;
  localparam logic [CfgW-1:0]  Mult45Rst    = 64'd55834574859;
  localparam logic [KeyW-1:0]  MultSixRst   = 32'd17;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [ModW-1:0]      modulus;
  } mod_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [ModW-1:0] rem;
  } mod_rsp_t;

endpackage

// File: sv/bloom_filter_add_test.sv
// Bloom filter add/test top level: sequencer, config registers, bit store.
// Depends on bfat_pkg, bfat_ram and bfat_mod.
//
// Input channel (in_valid/in_stall): in_cmd selects test or add, in_key_hash
// is the signed key hash. One item is taken at a time; in_stall is high
// while an item is being worked on.
// Result channel (out_valid/out_stall): one out_present per item, held in an
// output register until taken, so the next item may enter meanwhile.
// Each probe takes a multiply step, a start step, the bit-serial modulo unit
// and, for test, a read of the bit store; each item adds an accept step and
// a finish step. A test ends at the first clear bit. The modulo unit takes
// most of the time of each probe.
// After reset the bit store is swept to zero, one entry a cycle, over all
// MAX_BITS entries; no item is taken during the sweep, config writes are.
// When the receiver stalls, a finished result waits in its register and the
// following item, once done, waits for it to be taken.
module bloom_filter_add_test #(
  parameter int unsigned MAX_BITS   = 4096,
  parameter int unsigned MAX_HASHES = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic signed [bfat_pkg::KeyW-1:0] in_key_hash,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_present,
  input  logic                             cfg_we,
  input  logic [bfat_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bfat_pkg::CfgW-1:0]        cfg_data
);
  import bfat_pkg::*;

  localparam int IdxW = $clog2(MAX_BITS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_CHK   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [ModW-1:0]  bit_count_r;
  logic [HcntW-1:0] hash_count_r;
  logic [CfgW-1:0]  mult01_r, mult23_r, mult45_r;
  logic [KeyW-1:0]  mult_six_r;

  logic [2:0]       state_r, state_nxt;
  logic [IdxW-1:0]  clr_r, clr_nxt;
  logic [HcntW-1:0] i_r, i_nxt;
  logic             cmd_r, cmd_nxt;
  logic [KeyW-1:0]  key_r, key_nxt;
  logic [KeyW-1:0]  prod_r, prod_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic             pres_r, pres_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_present_r, out_present_nxt;

  logic [ModW-1:0]  m_eff;
  logic [HcntW-1:0] k_eff;
  logic [KeyW-1:0]  mult_sel;
  logic             in_acc;
  logic             last_probe;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic             ram_wdata;
  logic             ram_rdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= BitCountRst;
      hash_count_r <= HashCountRst;
      mult01_r     <= Mult01Rst;
      mult23_r     <= Mult23Rst;
      mult45_r     <= Mult45Rst;
      mult_six_r   <= MultSixRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBitCount:  bit_count_r  <= cfg_data[ModW-1:0];
        RegHashCount: hash_count_r <= cfg_data[HcntW-1:0];
        RegMult01:    mult01_r     <= cfg_data;
        RegMult23:    mult23_r     <= cfg_data;
        RegMult45:    mult45_r     <= cfg_data;
        RegMultSix:   mult_six_r   <= cfg_data[KeyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    m_eff = bit_count_r;
    if (bit_count_r == '0) begin
      m_eff = ModW'(1);
    end else if (32'(bit_count_r) > MAX_BITS) begin
      m_eff = ModW'(MAX_BITS);
    end
    k_eff = hash_count_r;
    if (32'(hash_count_r) > MAX_HASHES) begin
      k_eff = HcntW'(MAX_HASHES);
    end
  end

  always_comb begin
    unique case (i_r)
      3'd0:    mult_sel = mult01_r[KeyW-1:0];
      3'd1:    mult_sel = mult01_r[CfgW-1:KeyW];
      3'd2:    mult_sel = mult23_r[KeyW-1:0];
      3'd3:    mult_sel = mult23_r[CfgW-1:KeyW];
      3'd4:    mult_sel = mult45_r[KeyW-1:0];
      3'd5:    mult_sel = mult45_r[CfgW-1:KeyW];
      default: mult_sel = mult_six_r;
    endcase
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign last_probe = ((i_r + 3'd1) == k_eff);

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    i_nxt           = i_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    prod_nxt        = prod_r;
    idx_nxt         = idx_r;
    pres_nxt        = pres_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_present_nxt = out_present_r;
    ram_we          = 1'b0;
    ram_waddr       = IdxW'(mod_rsp.rem);
    ram_wdata       = 1'b1;
    mod_req.start    = 1'b0;
    mod_req.dividend = {{KeyW{prod_r[KeyW-1]}}, prod_r};
    mod_req.modulus  = m_eff;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IdxW'(MAX_BITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_cmd;
          key_nxt  = in_key_hash;
          pres_nxt = (in_cmd == CmdTest);
          i_nxt    = '0;
          if (k_eff == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = key_r * mult_sel;
        state_nxt = ST_START;
      end
      ST_START: begin
        mod_req.start = 1'b1;
        state_nxt     = ST_MOD;
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          idx_nxt = IdxW'(mod_rsp.rem);
          if (cmd_r == CmdAdd) begin
            ram_we = 1'b1;
            i_nxt  = i_r + 3'd1;
            state_nxt = last_probe ? ST_FIN : ST_MUL;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!ram_rdata) begin
          pres_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = last_probe ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = pres_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    prod_r        <= prod_nxt;
    idx_r         <= idx_nxt;
    pres_r        <= pres_nxt;
    out_present_r <= out_present_nxt;
  end

  bfat_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  bfat_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;

`ifndef SYNTHESIS
  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ST_MOD))
    else $error("modulo result outside the wait state");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || (state_r == ST_MOD && cmd_r == CmdAdd)))
    else $error("bit store written outside clear or add");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (i_r < k_eff))
    else $error("probe counter beyond hash count");

  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !mod_rsp.busy)
    else $error("item taken while modulo unit busy");
`endif

endmodule

// File: sv/bfat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bfat_mod.sv
// Bit-serial restoring modulo unit: 64-bit dividend by a 13-bit modulus.
// Depends on bfat_pkg for the request and response types.
module bfat_mod (
  input  logic               clk,
  input  logic               rst_n,
  input  bfat_pkg::mod_req_t req,
  output bfat_pkg::mod_rsp_t rsp
);
  import bfat_pkg::*;

  localparam int CntW = $clog2(DividendW);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [DividendW-1:0] d_r, d_nxt;
  logic [ModW-1:0]      rem_r, rem_nxt;
  logic [ModW-1:0]      mod_r, mod_nxt;
  logic [ModW:0]        trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    trial    = {rem_r, d_r[DividendW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      d_nxt    = req.dividend;
      rem_nxt  = '0;
      mod_nxt  = req.modulus;
    end else if (busy_r) begin
      d_nxt   = {d_r[DividendW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (trial >= {1'b0, mod_r}) begin
        rem_nxt = ModW'(trial - {1'b0, mod_r});
      end else begin
        rem_nxt = ModW'(trial);
      end
      if (cnt_r == CntW'(DividendW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
